// File: rtl/core/pcm_format_rate_converter_assert.svh
// Assertion macros used by the converter's top-level RTL.
`ifndef PCM_FORMAT_RATE_CONVERTER_ASSERT_SVH
`define PCM_FORMAT_RATE_CONVERTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PFRC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PFRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/pfrc_pkg.sv
// Types and constants of the PCM format and rate converter.
package pfrc_pkg;

    localparam int RateW  = 18;
    localparam int NumW   = 19;
    localparam int PhaseW = 20;
    localparam int CountW = 24;
    localparam int CfgIdxW = 3;

    localparam logic [CfgIdxW-1:0] CfgSrcFormat = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgSrcStereo = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgDstFormat = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgDstStereo = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgSrcRate   = 3'd4;
    localparam logic [CfgIdxW-1:0] CfgDstRate   = 3'd5;
    localparam logic [CfgIdxW-1:0] CfgMaxOut    = 3'd6;

    localparam logic [1:0] SrcS16 = 2'd0;
    localparam logic [1:0] SrcF32 = 2'd1;

    localparam logic DstU8  = 1'b0;
    localparam logic DstS16 = 1'b1;

    typedef struct packed {
        logic dst_format;
        logic dst_stereo;
    } t_out_fmt;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic [7:0]         byte_val;
    } t_frame;

    typedef struct packed {
        logic [NumW-1:0]  quot;
        logic [RateW-1:0] rem;
    } t_div_res;

endpackage

// File: rtl/core/pfrc_lane.sv
// One channel lane: decodes an S16 or float32 word into a signed 16-bit sample.
module pfrc_lane
    import pfrc_pkg::*;
(
    input  logic               i_clk,
    input  logic [31:0]        i_word,
    input  logic [1:0]         i_src_format,
    output logic signed [15:0] o_sample
);

    // Stage one: classify and form the exact product of mantissa and 32767.
    logic [38:0]        r_prod;
    logic [7:0]         r_exp;
    logic               r_sign;
    logic               r_nan;
    logic               r_big;
    logic               r_tiny;
    logic [1:0]         r_fmt;
    logic signed [15:0] r_int;

    logic [7:0]  w_exp;
    logic [22:0] w_frac;

    assign w_exp  = i_word[30:23];
    assign w_frac = i_word[22:0];

    always_ff @(posedge i_clk) begin
        r_prod <= 39'({1'b1, w_frac}) * 39'd32767;
        r_exp  <= w_exp;
        r_sign <= i_word[31];
        r_nan  <= (w_exp == 8'hFF) && (w_frac != 23'd0);
        r_big  <= (w_exp > 8'd127) || ((w_exp == 8'd127) && (w_frac != 23'd0));
        r_tiny <= (w_exp == 8'd0);
        r_fmt  <= i_src_format;
        r_int  <= $signed(i_word[15:0]);
    end

    // Stage two: round the product to single precision, then truncate.
    logic [23:0] w_mant;
    logic        w_guard;
    logic        w_sticky;
    logic [24:0] w_round;
    logic [7:0]  w_shift;
    logic [24:0] w_mag;
    logic signed [15:0] w_float;
    logic signed [15:0] n_sample;

    always_comb begin
        if (r_prod[38]) begin
            w_mant   = r_prod[38:15];
            w_guard  = r_prod[14];
            w_sticky = |r_prod[13:0];
            w_shift  = 8'd135 - r_exp;
        end else begin
            w_mant   = r_prod[37:14];
            w_guard  = r_prod[13];
            w_sticky = |r_prod[12:0];
            w_shift  = 8'd136 - r_exp;
        end
        w_round = {1'b0, w_mant} + 25'(w_guard && (w_sticky || w_mant[0]));
        w_mag   = (w_shift > 8'd24) ? 25'd0 : (w_round >> w_shift[4:0]);
        if (r_nan || r_tiny) begin
            w_float = 16'sd0;
        end else if (r_big) begin
            w_float = r_sign ? -16'sd32767 : 16'sd32767;
        end else begin
            w_float = r_sign ? -$signed(w_mag[15:0]) : $signed(w_mag[15:0]);
        end
        case (r_fmt)
            SrcS16:  n_sample = r_int;
            SrcF32:  n_sample = w_float;
            default: n_sample = 16'sd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        o_sample <= n_sample;
    end

endmodule

// File: rtl/core/pfrc_merge.sv
// Merging stage: combines the two lane samples into the target frame format.
module pfrc_merge
    import pfrc_pkg::*;
(
    input  logic               i_clk,
    input  logic signed [15:0] i_left,
    input  logic signed [15:0] i_right,
    input  t_out_fmt           i_fmt,
    output t_frame             o_frame
);

    logic signed [16:0] w_sum;
    logic signed [16:0] w_avg;
    t_frame             n_frame;

    always_comb begin
        w_sum = 17'(i_left) + 17'(i_right);
        // Halve with truncation toward zero.
        w_avg = (w_sum + 17'(w_sum[16])) >>> 1;
        n_frame = '0;
        if (i_fmt.dst_stereo) begin
            if (i_fmt.dst_format == DstS16) begin
                n_frame.left  = i_left;
                n_frame.right = i_right;
            end
        end else if (i_fmt.dst_format == DstS16) begin
            n_frame.left = w_avg[15:0];
        end else begin
            n_frame.byte_val = {~w_avg[15], w_avg[14:8]};
        end
    end

    always_ff @(posedge i_clk) begin
        o_frame <= n_frame;
    end

endmodule

// File: rtl/core/pfrc_div.sv
// Restoring divider, one quotient bit per cycle.
module pfrc_div
    import pfrc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NumW-1:0]  i_num,
    input  logic [RateW-1:0] i_den,
    output logic             o_done,
    output t_div_res         o_res
);

    logic              r_busy;
    logic [4:0]        r_cnt;
    logic [NumW-1:0]   r_num;
    logic [RateW-1:0]  r_den;
    logic [RateW-1:0]  r_rem;
    logic [NumW-1:0]   r_quot;

    logic [RateW:0] w_trial;
    logic           w_fit;

    assign w_trial = {r_rem, r_num[NumW-1]};
    assign w_fit   = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(NumW - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num  <= {r_num[NumW-2:0], 1'b0};
            r_rem  <= w_fit ? RateW'(w_trial - {1'b0, r_den}) : w_trial[RateW-1:0];
            r_quot <= {r_quot[NumW-2:0], w_fit};
        end
    end

    assign o_res.quot = r_quot;
    assign o_res.rem  = r_rem;

endmodule

// File: rtl/core/pcm_format_rate_converter.sv
// The first result frame of an item is offered once the 19-step phase divider has
// finished; the item then holds the block until its result frames have been taken,
// each as the sink accepts it, and the next item is taken after the last result frame
// has been delivered (or as soon as the division ends when an item causes none).
// Reset (synchronous, active low) restores the register defaults and clears the phase
// accumulator and frame count.
module pcm_format_rate_converter
    import pfrc_pkg::*;
#(
    parameter int MAX_FANOUT = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic [CountW-1:0]  i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [31:0]        i_left_word,
    input  logic [31:0]        i_right_word,
    input  logic               i_final_frame,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_out_left,
    output logic signed [15:0] o_out_right,
    output logic [7:0]         o_out_byte,
    output logic               o_run_end,
    output logic               o_fanout_overflow
);

    localparam int FanW = $clog2(MAX_FANOUT + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_EMIT
    } t_state;

    t_state r_state;

    logic [1:0]        r_src_format;
    logic              r_src_stereo;
    logic              r_dst_format;
    logic              r_dst_stereo;
    logic [RateW-1:0]  r_src_rate;
    logic [RateW-1:0]  r_dst_rate;
    logic [CountW-1:0] r_max_out;
    logic [PhaseW-1:0] r_phase;
    logic [CountW-1:0] r_emitted;

    logic [31:0]       r_lw;
    logic [31:0]       r_rw;
    logic              r_final;
    logic              r_skip;
    logic [RateW-1:0]  r_sr;
    logic [RateW-1:0]  r_dr;
    logic [FanW-1:0]   r_n;
    logic [FanW-1:0]   r_cnt;
    logic              r_ovf;

    logic              w_accept;
    logic [RateW-1:0]  w_sr;
    logic [RateW-1:0]  w_dr;
    logic [PhaseW-1:0] w_num;
    logic              w_div_done;
    t_div_res          w_div;
    logic [NumW-1:0]   w_due;
    logic [PhaseW-1:0] n_phase;
    logic [CountW-1:0] w_remaining;
    logic [CountW-1:0] w_eff;
    logic [FanW-1:0]   n_n;
    logic              n_ovf;

    logic signed [15:0] w_left;
    logic signed [15:0] w_right;
    t_out_fmt           w_fmt;
    t_frame             w_frame;

    assign w_accept = i_in_valid && o_in_ready;
    assign w_sr     = (r_src_rate == '0) ? RateW'(1) : r_src_rate;
    assign w_dr     = (r_dst_rate == '0) ? RateW'(1) : r_dst_rate;
    // Numerator of the ceiling division for frames due; fits 19 bits when used.
    assign w_num    = PhaseW'(w_dr) - r_phase + PhaseW'(w_sr) - PhaseW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_format <= SrcS16;
            r_src_stereo <= 1'b0;
            r_dst_format <= DstS16;
            r_dst_stereo <= 1'b0;
            r_src_rate   <= RateW'(44100);
            r_dst_rate   <= RateW'(44100);
            r_max_out    <= CountW'(32768);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CfgSrcFormat: r_src_format <= i_cfg_data[1:0];
                CfgSrcStereo: r_src_stereo <= i_cfg_data[0];
                CfgDstFormat: r_dst_format <= i_cfg_data[0];
                CfgDstStereo: r_dst_stereo <= i_cfg_data[0];
                CfgSrcRate:   r_src_rate   <= i_cfg_data[RateW-1:0];
                CfgDstRate:   r_dst_rate   <= i_cfg_data[RateW-1:0];
                CfgMaxOut:    r_max_out    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_lw    <= i_left_word;
            r_rw    <= r_src_stereo ? i_right_word : i_left_word;
            r_final <= i_final_frame;
            r_skip  <= r_phase >= PhaseW'(w_dr);
            r_sr    <= w_sr;
            r_dr    <= w_dr;
        end
    end

    pfrc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_num   (w_num[NumW-1:0]),
        .i_den   (w_sr),
        .o_done  (w_div_done),
        .o_res   (w_div)
    );

    pfrc_lane u_lane_left (
        .i_clk        (i_clk),
        .i_word       (r_lw),
        .i_src_format (r_src_format),
        .o_sample     (w_left)
    );

    pfrc_lane u_lane_right (
        .i_clk        (i_clk),
        .i_word       (r_rw),
        .i_src_format (r_src_format),
        .o_sample     (w_right)
    );

    assign w_fmt.dst_format = r_dst_format;
    assign w_fmt.dst_stereo = r_dst_stereo;

    pfrc_merge u_merge (
        .i_clk   (i_clk),
        .i_left  (w_left),
        .i_right (w_right),
        .i_fmt   (w_fmt),
        .o_frame (w_frame)
    );

    always_comb begin
        w_due   = r_skip ? '0 : w_div.quot;
        // With q*sr + rem = dr - d + sr - 1 the new phase is sr - 1 - rem.
        n_phase = r_skip ? (r_phase - PhaseW'(r_dr))
                         : PhaseW'(r_sr - RateW'(1) - w_div.rem);
        w_remaining = (r_emitted < r_max_out) ? (r_max_out - r_emitted) : '0;
        w_eff   = (CountW'(w_due) < w_remaining) ? CountW'(w_due) : w_remaining;
        n_n     = (w_eff < CountW'(MAX_FANOUT)) ? FanW'(w_eff) : FanW'(MAX_FANOUT);
        n_ovf   = w_eff > CountW'(MAX_FANOUT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= '0;
            r_emitted <= '0;
            r_cnt     <= '0;
            r_n       <= '0;
            r_ovf     <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    if (w_div_done) begin
                        if (r_final) begin
                            r_phase   <= '0;
                            r_emitted <= '0;
                        end else begin
                            r_phase   <= n_phase;
                            r_emitted <= r_emitted + w_eff;
                        end
                        r_n     <= n_n;
                        r_ovf   <= n_ovf;
                        r_cnt   <= '0;
                        r_state <= (n_n == '0) ? S_IDLE : S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (i_out_ready) begin
                        r_cnt <= r_cnt + FanW'(1);
                        if (r_cnt + FanW'(1) == r_n) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready        = (r_state == S_IDLE);
    assign o_out_valid       = (r_state == S_EMIT);
    assign o_out_left        = w_frame.left;
    assign o_out_right       = w_frame.right;
    assign o_out_byte        = w_frame.byte_val;
    assign o_run_end         = (r_cnt + FanW'(1) == r_n);
    assign o_fanout_overflow = r_ovf;

`include "pcm_format_rate_converter_assert.svh"

    `PFRC_ASSERT_NOW(a_no_overlap, o_out_valid, !o_in_ready, "input taken while emitting")
    `PFRC_ASSERT_NEXT(a_busy_after_take, w_accept, !o_in_ready && !o_out_valid, "no busy phase")
    `PFRC_ASSERT_NEXT(a_end_stops, o_out_valid && i_out_ready && o_run_end, !o_out_valid, "extra item")
    `PFRC_ASSERT_NOW(a_count_bound, o_out_valid, r_cnt < r_n, "more items than due")

endmodule

// File: tb/sv/pcm_format_rate_converter_tb.sv
// Self-checking testbench for the PCM format and rate converter.
module pcm_format_rate_converter_tb
    import pfrc_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] left_word;
        logic [31:0] right_word;
        logic        final_frame;
    } t_src_frame;

    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic [7:0]         byte_val;
        logic               run_end;
        logic               overflow;
    } t_out_frame;

    localparam int Fanout = 64;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0] i_cfg_index = '0;
    logic [CountW-1:0]  i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [31:0]        i_left_word = '0;
    logic [31:0]        i_right_word = '0;
    logic               i_final_frame = 1'b0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [15:0] o_out_left;
    logic signed [15:0] o_out_right;
    logic [7:0]         o_out_byte;
    logic               o_run_end;
    logic               o_fanout_overflow;

    pcm_format_rate_converter #(.MAX_FANOUT(Fanout)) DUT (.*);

    // Shadow copy of the registers and the resampler state.
    logic [1:0]        src_fmt = SrcS16;
    logic              src_st = 1'b0;
    logic              dst_fmt = DstS16;
    logic              dst_st = 1'b0;
    logic [RateW-1:0]  src_hz = 18'd44100;
    logic [RateW-1:0]  dst_hz = 18'd44100;
    logic [CountW-1:0] frame_cap = 24'd32768;
    logic [PhaseW-1:0] phase = '0;
    logic [CountW-1:0] frames_due = '0;

    t_src_frame pending_frames[$];
    t_out_frame expected_frames[$];
    int errors = 0;
    int in_gap = 0;
    int out_gap = 0;
    bit in_calm = 1'b0;
    bit out_calm = 1'b0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // The product is rounded to a 24-bit significand, ties to even, then truncated.
    function automatic int float_to_s16(logic [31:0] bits);
        longint mant;
        longint prod;
        longint keep;
        longint rest;
        longint half;
        int e;
        int sh;
        if (bits[30:23] == 8'hff && bits[22:0] != 0) return 0;
        e = int'(bits[30:23]);
        if (e == 0) return 0;
        if (e > 127 || (e == 127 && bits[22:0] != 0)) return bits[31] ? -32767 : 32767;
        mant = longint'({1'b1, bits[22:0]});
        prod = mant * 32767;
        sh = (prod >= (longint'(1) << 38)) ? 15 : 14;
        keep = prod >> sh;
        rest = prod - (keep << sh);
        half = longint'(1) << (sh - 1);
        if (rest > half || (rest == half && keep[0])) keep++;
        sh = 150 - e - sh;
        keep = (sh > 40) ? 0 : (keep >> sh);
        return bits[31] ? -int'(keep) : int'(keep);
    endfunction

    function automatic int decode_sample(logic [31:0] bits);
        if (src_fmt == SrcS16) return int'($signed(bits[15:0]));
        if (src_fmt == SrcF32) return float_to_s16(bits);
        return 0;
    endfunction

    function automatic void predict_frames(t_src_frame f);
        longint sr, dr, d, due, remaining, eff, n;
        int l, r, avg;
        t_out_frame o;
        sr = (src_hz == 0) ? 1 : src_hz;
        dr = (dst_hz == 0) ? 1 : dst_hz;
        d = phase;
        due = 0;
        if (d < dr) due = (dr - d + sr - 1) / sr;
        d = d + due * sr - dr;
        remaining = (frames_due < frame_cap) ? frame_cap - frames_due : 0;
        eff = (due < remaining) ? due : remaining;
        n = (eff < Fanout) ? eff : Fanout;
        l = decode_sample(f.left_word);
        r = src_st ? decode_sample(f.right_word) : l;
        o = '{default: '0};
        o.overflow = eff > Fanout;
        if (dst_st) begin
            if (dst_fmt == DstS16) begin
                o.left = l[15:0];
                o.right = r[15:0];
            end
        end else begin
            avg = (l + r) / 2;
            if (dst_fmt == DstS16) o.left = avg[15:0];
            else o.byte_val = 8'((avg + 32768) >> 8);
        end
        for (longint k = 0; k < n; k++) begin
            o.run_end = (k + 1 == n);
            expected_frames.push_back(o);
        end
        if (f.final_frame) begin
            phase = '0;
            frames_due = '0;
        end else begin
            phase = d[PhaseW-1:0];
            frames_due = frames_due + eff[CountW-1:0];
        end
    endfunction

    function automatic int draw_gap(bit calm);
        return calm ? 0 : $urandom_range(0, 15);
    endfunction

    // Source side: one item at a time from the pending queue, with random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) predict_frames('{i_left_word, i_right_word,
                                                           i_final_frame});
            if (!(i_in_valid && !o_in_ready)) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_frames.size() > 0) begin
                    t_src_frame f;
                    f = pending_frames.pop_front();
                    i_left_word <= f.left_word;
                    i_right_word <= f.right_word;
                    i_final_frame <= f.final_frame;
                    i_in_valid <= 1'b1;
                    if ($urandom_range(0, 19) == 0) in_calm = ~in_calm;
                    in_gap = draw_gap(in_calm);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Sink side: random back-pressure and comparison against the oldest expectation.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_frames.size() == 0) begin
                    $error("unexpected output item");
                    errors++;
                end else begin
                    t_out_frame e;
                    e = expected_frames.pop_front();
                    if (o_out_left !== e.left) begin
                        $error("out_left: expected %0d, got %0d", e.left, o_out_left);
                        errors++;
                    end
                    if (o_out_right !== e.right) begin
                        $error("out_right: expected %0d, got %0d", e.right, o_out_right);
                        errors++;
                    end
                    if (o_out_byte !== e.byte_val) begin
                        $error("out_byte: expected %0d, got %0d", e.byte_val, o_out_byte);
                        errors++;
                    end
                    if (o_run_end !== e.run_end) begin
                        $error("run_end: expected %0d, got %0d", e.run_end, o_run_end);
                        errors++;
                    end
                    if (o_fanout_overflow !== e.overflow) begin
                        $error("fanout_overflow: expected %0d, got %0d", e.overflow,
                               o_fanout_overflow);
                        errors++;
                    end
                end
                if ($urandom_range(0, 19) == 0) out_calm = ~out_calm;
                out_gap = draw_gap(out_calm);
            end
            if (out_gap > 0) begin
                out_gap--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CountW-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CfgSrcFormat: src_fmt = value[1:0];
            CfgSrcStereo: src_st = value[0];
            CfgDstFormat: dst_fmt = value[0];
            CfgDstStereo: dst_st = value[0];
            CfgSrcRate:   src_hz = value[RateW-1:0];
            CfgDstRate:   dst_hz = value[RateW-1:0];
            CfgMaxOut:    frame_cap = value;
            default: ;
        endcase
    endtask

    task automatic setup(logic [1:0] sf, logic ss, logic df, logic ds,
                         logic [CountW-1:0] sr, logic [CountW-1:0] dr,
                         logic [CountW-1:0] cap);
        write_reg(CfgSrcFormat, CountW'(sf));
        write_reg(CfgSrcStereo, CountW'(ss));
        write_reg(CfgDstFormat, CountW'(df));
        write_reg(CfgDstStereo, CountW'(ds));
        write_reg(CfgSrcRate, sr);
        write_reg(CfgDstRate, dr);
        write_reg(CfgMaxOut, cap);
    endtask

    // Waits, sampling on the falling edge, until every item has been taken and the
    // block is idle again; items with no output keep it busy without any expectation.
    task automatic drain();
        do begin
            @(negedge i_clk);
        end while (!(pending_frames.size() == 0 && !i_in_valid && o_in_ready
                     && expected_frames.size() == 0));
        repeat (4) @(posedge i_clk);
    endtask

    task automatic push(logic [31:0] lw, logic [31:0] rw, logic fin);
        pending_frames.push_back('{lw, rw, fin});
    endtask

    // Mostly floats near full scale, sometimes arbitrary bit patterns.
    function automatic logic [31:0] rand_word();
        logic [31:0] w;
        w = $urandom();
        if ($urandom_range(0, 3) != 0) w[30:23] = 8'($urandom_range(118, 128));
        return w;
    endfunction

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Register defaults: signed 16-bit mono in, same rate out.
        push(32'h0000_7fff, 32'h0, 1'b0);
        push(32'hffff_8000, 32'h0, 1'b0);
        push(32'h1234_0000, 32'h0, 1'b0);
        push(32'h0000_ffff, 32'h0, 1'b1);
        drain();

        // Float stereo, eight-fold upsampling, with NaN, infinities and clamping.
        setup(SrcF32, 1'b1, DstS16, 1'b1, 24'd1, 24'd8, 24'd16777215);
        push(32'h7fc0_0000, 32'hff80_0000, 1'b0);
        push(32'h7f80_0000, 32'h3f00_0000, 1'b0);
        push(32'h3fc0_0000, 32'hc000_0000, 1'b0);
        push(32'h0000_0001, 32'h8000_0000, 1'b0);
        push(32'h3f80_0000, 32'hbf80_0000, 1'b1);
        drain();

        // Zero source rate counts as one; more frames due than the fan-out allows.
        setup(SrcS16, 1'b1, DstU8, 1'b0, 24'd0, 24'd100, 24'd250);
        push(32'h0000_7fff, 32'h0000_7fff, 1'b0);
        push(32'h0000_8000, 32'h0000_8000, 1'b0);
        push(32'h0000_8000, 32'h0000_7fff, 1'b0);
        push(32'h0000_0001, 32'h0000_ffff, 1'b0);
        push(32'h0000_1234, 32'h0000_4321, 1'b1);
        drain();

        // Unused format gives silence; a stereo 8-bit target gives zeros.
        setup(2'd3, 1'b0, DstU8, 1'b1, 24'd2, 24'd3, 24'd0);
        push(32'hffff_ffff, 32'hffff_ffff, 1'b0);
        drain();
        write_reg(CfgMaxOut, 24'd5);
        push(32'hffff_ffff, 32'hffff_ffff, 1'b0);
        push(32'h5555_5555, 32'haaaa_aaaa, 1'b0);
        push(32'h0, 32'h0, 1'b0);
        push(32'hffff_ffff, 32'hffff_ffff, 1'b1);
        drain();

        // Heavy downsampling: most items cause nothing.
        setup(SrcF32, 1'b0, DstU8, 1'b0, 24'hffffff, 24'd40000, 24'hffffff);
        for (int i = 0; i < 12; i++) push(rand_word(), rand_word(), i == 11);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            logic [CountW-1:0] sr;
            sr = CountW'($urandom_range(1, 262143));
            setup(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), sr,
                  $urandom_range(0, 1) ? CountW'($urandom_range(1, 262143))
                                       : CountW'($urandom_range(1, 2 * sr + 1) & 24'h3ffff),
                  $urandom_range(0, 3) == 0 ? CountW'($urandom_range(0, 40))
                                            : CountW'($urandom()));
            for (int i = 0; i < 10; i++)
                push(rand_word(), rand_word(), $urandom_range(0, 15) == 0);
            drain();
        end

        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/pfrc_pkg.sv
rtl/core/pfrc_lane.sv
rtl/core/pfrc_merge.sv
rtl/core/pfrc_div.sv
rtl/core/pcm_format_rate_converter.sv
tb/sv/pcm_format_rate_converter_tb.sv
